// File: hdl/ptob_pkg.sv
// Shared types and codes for the price-time order book.
`timescale 1ns / 1ps
package ptob_pkg;

  localparam int PriceW  = 32;
  localparam int VolumeW = 32;
  localparam int RefW    = 31;

  localparam logic FuncAdd  = 1'b0;
  localparam logic FuncDump = 1'b1;

  localparam logic SideBuy  = 1'b0;
  localparam logic SideSell = 1'b1;

  typedef enum logic [1:0] {
    StatusAccepted = 2'd0,
    StatusFull     = 2'd1,
    StatusEntry    = 2'd2,
    StatusEmpty    = 2'd3
  } status_e;

  typedef struct packed {
    logic [RefW-1:0]    user_ref;
    logic [VolumeW-1:0] volume;
    logic [PriceW-1:0]  price;
  } entry_t;

  typedef struct packed {
    logic ins_en;
    logic rot_en;
  } side_ctrl_t;

endpackage

// File: hdl/price_time_order_book_unit.sv
// Top level of the price-time priority order book.
`timescale 1ns / 1ps
// Two sorted books of BOOK_DEPTH entries each, held in chains of cells: sell
// ascending by price, buy descending, equal prices in arrival order. An add
// request inserts the order and returns one status (accepted or side full,
// order dropped). A dump request streams every sell entry, then every buy
// entry, one per cycle as the output takes them, with tlast on the final one;
// an empty book gives one empty result. A non-empty dump first enters its dump
// state, then gives one result per step, rotating the chain being dumped one
// slot per result; input is not taken during a dump. A result waits in an
// output register, and the next add request is taken in the same cycle that
// register is drained.
module price_time_order_book_unit #(
  parameter int BOOK_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // side[0], price[32:1], volume[64:33], user_ref[95:65]
  input  logic [95:0]  s_axis_tdata_i,
  // func[0]
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // entry_side[0], entry_price[32:1], entry_volume[64:33], entry_ref[95:65]
  output logic [95:0]  m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  localparam int FillW = $clog2(BOOK_DEPTH + 1);
  localparam int CntW  = $clog2(BOOK_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  state_e                state_q;
  logic                  dump_sell_q;
  logic [CntW-1:0]       cnt_q;
  logic                  m_valid_q;
  ptob_pkg::status_e     status_q;
  logic                  out_side_q;
  ptob_pkg::entry_t      out_entry_q;
  logic                  out_last_q;

  ptob_pkg::entry_t      new_entry;
  logic                  in_side;
  logic                  in_func;
  ptob_pkg::side_ctrl_t  sell_ctrl, buy_ctrl;
  ptob_pkg::entry_t      sell_head, buy_head, cur_head;
  logic [FillW-1:0]      sell_fill, buy_fill, cur_fill;
  logic                  sell_full, buy_full;
  logic                  out_free, in_acc, step, cur_end;

  assign in_side            = s_axis_tdata_i[0];
  assign new_entry.price    = s_axis_tdata_i[32:1];
  assign new_entry.volume   = s_axis_tdata_i[64:33];
  assign new_entry.user_ref = s_axis_tdata_i[95:65];
  assign in_func            = s_axis_tuser_i;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign step            = (state_q == ST_DUMP) && out_free;

  always_comb begin
    sell_ctrl.ins_en = in_acc && (in_func == ptob_pkg::FuncAdd)
                       && (in_side == ptob_pkg::SideSell) && !sell_full;
    buy_ctrl.ins_en  = in_acc && (in_func == ptob_pkg::FuncAdd)
                       && (in_side == ptob_pkg::SideBuy) && !buy_full;
    sell_ctrl.rot_en = step && dump_sell_q;
    buy_ctrl.rot_en  = step && !dump_sell_q;
  end

  ptob_side #(.DEPTH(BOOK_DEPTH), .IS_SELL(1'b1)) u_sell (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (sell_ctrl),
    .new_entry_i (new_entry),
    .head_o      (sell_head),
    .fill_o      (sell_fill),
    .full_o      (sell_full)
  );

  ptob_side #(.DEPTH(BOOK_DEPTH), .IS_SELL(1'b0)) u_buy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (buy_ctrl),
    .new_entry_i (new_entry),
    .head_o      (buy_head),
    .fill_o      (buy_fill),
    .full_o      (buy_full)
  );

  assign cur_head = dump_sell_q ? sell_head : buy_head;
  assign cur_fill = dump_sell_q ? sell_fill : buy_fill;
  assign cur_end  = (FillW'(cnt_q) + FillW'(1)) == cur_fill;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dump_sell_q <= 1'b0;
      cnt_q       <= '0;
      m_valid_q   <= 1'b0;
      status_q    <= ptob_pkg::StatusAccepted;
      out_side_q  <= 1'b0;
      out_entry_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            out_side_q  <= 1'b0;
            out_entry_q <= '0;
            out_last_q  <= 1'b1;
            if (in_func == ptob_pkg::FuncAdd) begin
              m_valid_q <= 1'b1;
              if ((in_side == ptob_pkg::SideSell) ? sell_full : buy_full) begin
                status_q <= ptob_pkg::StatusFull;
              end else begin
                status_q <= ptob_pkg::StatusAccepted;
              end
            end else if (sell_fill == '0 && buy_fill == '0) begin
              m_valid_q <= 1'b1;
              status_q  <= ptob_pkg::StatusEmpty;
            end else begin
              m_valid_q   <= 1'b0;
              state_q     <= ST_DUMP;
              dump_sell_q <= sell_fill != '0;
              cnt_q       <= '0;
            end
          end else if (m_axis_tready_i) begin
            m_valid_q <= 1'b0;
          end
        end
        ST_DUMP: begin
          if (step) begin
            m_valid_q   <= 1'b1;
            status_q    <= ptob_pkg::StatusEntry;
            out_side_q  <= dump_sell_q;
            out_entry_q <= cur_head;
            out_last_q  <= cur_end && (!dump_sell_q || buy_fill == '0);
            if (cur_end) begin
              cnt_q <= '0;
              if (dump_sell_q && buy_fill != '0) begin
                dump_sell_q <= 1'b0;
              end else begin
                state_q <= ST_IDLE;
              end
            end else begin
              cnt_q <= cnt_q + CntW'(1);
            end
          end else if (m_axis_tready_i) begin
            m_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          if (m_axis_tready_i) begin
            m_valid_q <= 1'b0;
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {out_entry_q.user_ref, out_entry_q.volume,
                            out_entry_q.price, out_side_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sell_fill <= FillW'(BOOK_DEPTH)) && (buy_fill <= FillW'(BOOK_DEPTH)))
    else $error("book fill beyond depth");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (status_q != ptob_pkg::StatusEntry) |-> out_last_q)
    else $error("status result without last");

  a_no_insert_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> !sell_ctrl.ins_en && !buy_ctrl.ins_en)
    else $error("insert during dump");

  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (cur_fill != '0))
    else $error("dumping an empty side");
`endif

endmodule

// File: hdl/ptob_cell.sv
// One book slot: compares against a new order, inserts, shifts or rotates.
`timescale 1ns / 1ps
module ptob_cell #(
  parameter bit IS_SELL = 1'b0
) (
  input  logic                clk_i,
  input  ptob_pkg::side_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  logic                tail_i,
  input  logic                prev_worse_i,
  input  ptob_pkg::entry_t    prev_entry_i,
  input  ptob_pkg::entry_t    next_entry_i,
  input  ptob_pkg::entry_t    head_entry_i,
  input  ptob_pkg::entry_t    new_entry_i,
  output logic                worse_o,
  output ptob_pkg::entry_t    entry_o
);

  ptob_pkg::entry_t entry_q, entry_d;

  // empty slots count as worse so the new order lands at the fill point
  always_comb begin
    if (IS_SELL) begin
      worse_o = !valid_i || (entry_q.price > new_entry_i.price);
    end else begin
      worse_o = !valid_i || (entry_q.price < new_entry_i.price);
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en && worse_o) begin
      entry_d = prev_worse_i ? prev_entry_i : new_entry_i;
    end else if (ctrl_i.rot_en) begin
      entry_d = tail_i ? head_entry_i : next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: hdl/ptob_side.sv
// One sorted side of the book: a chain of cells plus its fill count.
`timescale 1ns / 1ps
module ptob_side #(
  parameter int DEPTH   = 16,
  parameter bit IS_SELL = 1'b0,
  parameter int FILL_W  = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptob_pkg::side_ctrl_t ctrl_i,
  input  ptob_pkg::entry_t     new_entry_i,
  output ptob_pkg::entry_t     head_o,
  output logic [FILL_W-1:0]    fill_o,
  output logic                 full_o
);

  logic [FILL_W-1:0] fill_q;
  logic [DEPTH-1:0]  worse;
  ptob_pkg::entry_t  entries [DEPTH];

  genvar k;
  for (k = 0; k < DEPTH; k++) begin : g_cell
    logic             prev_worse;
    ptob_pkg::entry_t prev_entry;
    ptob_pkg::entry_t next_entry;
    logic             valid;
    logic             tail;

    if (k == 0) begin : g_first
      assign prev_worse = 1'b0;
      assign prev_entry = new_entry_i;
    end else begin : g_mid
      assign prev_worse = worse[k-1];
      assign prev_entry = entries[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign next_entry = entries[0];
    end else begin : g_nxt
      assign next_entry = entries[k+1];
    end

    assign valid = FILL_W'(k) < fill_q;
    assign tail  = FILL_W'(k + 1) == fill_q;

    ptob_cell #(.IS_SELL(IS_SELL)) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_i),
      .valid_i      (valid),
      .tail_i       (tail),
      .prev_worse_i (prev_worse),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .head_entry_i (entries[0]),
      .new_entry_i  (new_entry_i),
      .worse_o      (worse[k]),
      .entry_o      (entries[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (ctrl_i.ins_en) begin
      fill_q <= fill_q + FILL_W'(1);
    end
  end

  assign full_o = fill_q == FILL_W'(DEPTH);
  assign fill_o = fill_q;
  assign head_o = entries[0];

endmodule
